FILE: design/tgd_pkg.sv
// Shared types, codes and constants for the multi-axis target guard.
package tgd_pkg;

	// Default number of axes
	localparam int AXES_DEFAULT = 8;

	// Width of the axis index field
	localparam int AXIS_W = 3;

	// Configuration port geometry
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 32;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_TORQUE_LIMIT = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_STEP     = 1'd1;

	// Axis operation modes
	localparam logic signed [7:0] MODE_POSITION = 8'sd8;
	localparam logic signed [7:0] MODE_VELOCITY = 8'sd9;
	localparam logic signed [7:0] MODE_TORQUE   = 8'sd10;

	// Target source outcomes
	localparam logic [1:0] SRC_UPDATED = 2'd0;
	localparam logic [1:0] SRC_HOLD    = 2'd1;

	// Round status codes
	localparam logic STATUS_OK      = 1'b0;
	localparam logic STATUS_INVALID = 1'b1;

	// One input item: a proposed target for one axis
	typedef struct packed {
		logic [AXIS_W-1:0]  axis_sel;
		logic signed [7:0]  mode;
		logic signed [31:0] target;
		logic               limits_known;
		logic signed [31:0] limit_min;
		logic signed [31:0] limit_max;
		logic               write_ok;
		logic [1:0]         source_status;
		logic               last_axis;
	} tgd_in_t;

	// One result item: the outcome of a round
	typedef struct packed {
		logic status;
		logic updated;
	} tgd_out_t;

	// Commands from the round control to the target store
	typedef struct packed {
		logic               wr_en;
		logic               commit;
		logic [AXIS_W-1:0]  axis;
		logic signed [31:0] target;
	} tgd_store_cmd_t;

endpackage

FILE: design/multi_axis_target_guard.sv
// Top level of the multi-axis target guard: item register, round control, result register.
module multi_axis_target_guard #(
	parameter int AXES = tgd_pkg::AXES_DEFAULT
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              tgt_valid,
	output logic                              tgt_stall,
	input  tgd_pkg::tgd_in_t                  tgt,
	output logic                              res_valid,
	input  logic                              res_stall,
	output tgd_pkg::tgd_out_t                 res,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [tgd_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [tgd_pkg::CFG_DATA_W-1:0]    cfg_data
);
	// One axis target item is taken per cycle unless the input stalls. Each item is registered, checked
	// against its soft limits, the torque bound and the step bound from the last
	// committed target in the following cycle, and folded into the round flags;
	// the item that ends a round loads the result register as it leaves the item
	// register, and the result register then presents the round's status.
	// Items that do not end a round never wait on the result side; a
	// round end waits only while a previous result is still held by a stall.
	// Axis indexes at or above AXES are neither stored nor checked but still
	// count toward the round's mode and write outcome. Configuration may be
	// written at any time the block is idle and is always ready.
	import tgd_pkg::*;

	tgd_in_t        tgt_s1;
	logic           vld_s1;
	tgd_out_t       res_q;
	logic           res_vld_q;
	logic           mode_bad_q;
	logic           check_fail_q;
	logic           write_fail_q;
	logic [15:0]    torque_limit_q;
	logic [31:0]    max_step_q;

	logic           out_free;
	logic           go_s1;
	logic           in_range;
	logic           item_ok;
	logic           mode_bad_n;
	logic           check_fail_n;
	logic           write_fail_n;
	logic           commit;
	logic           status_n;
	logic signed [31:0] committed_rd;
	logic           has_committed;
	tgd_store_cmd_t store_cmd;

	// Handshake: a round end needs a free result register
	assign out_free  = !res_vld_q || !res_stall;
	assign go_s1     = vld_s1 && (!tgt_s1.last_axis || out_free);
	assign tgt_stall = vld_s1 && !go_s1;
	assign cfg_ready = 1'b1;

	// Item register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (!tgt_stall) begin
			vld_s1 <= tgt_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (tgt_valid && !tgt_stall) begin
			tgt_s1 <= tgt;
		end
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			torque_limit_q <= '0;
			max_step_q     <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_TORQUE_LIMIT: torque_limit_q <= cfg_data[15:0];
				REG_MAX_STEP:     max_step_q     <= cfg_data[31:0];
				default:          ;
			endcase
		end
	end

	// Per-item checks
	tgd_check u_check (
		.item             (tgt_s1),
		.torque_limit     (torque_limit_q),
		.max_step         (max_step_q),
		.has_committed    (has_committed),
		.committed_target (committed_rd),
		.ok               (item_ok)
	);

	assign in_range = int'(tgt_s1.axis_sel) < AXES;

	// Round flags including the current item
	assign mode_bad_n   = mode_bad_q || !(tgt_s1.mode == MODE_POSITION ||
	                                      tgt_s1.mode == MODE_VELOCITY ||
	                                      tgt_s1.mode == MODE_TORQUE);
	assign check_fail_n = check_fail_q || (in_range && !item_ok);
	assign write_fail_n = write_fail_q || !tgt_s1.write_ok;

	// Round outcome in priority order
	always_comb begin
		commit   = 1'b0;
		status_n = STATUS_OK;
		if (mode_bad_n) begin
			status_n = STATUS_INVALID;
		end else if (tgt_s1.source_status == SRC_HOLD) begin
			status_n = STATUS_OK;
		end else if (tgt_s1.source_status != SRC_UPDATED) begin
			status_n = STATUS_INVALID;
		end else if (check_fail_n || write_fail_n) begin
			status_n = STATUS_INVALID;
		end else begin
			commit = 1'b1;
		end
	end

	// Round flag registers, cleared at every round end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_bad_q   <= 1'b0;
			check_fail_q <= 1'b0;
			write_fail_q <= 1'b0;
		end else if (go_s1) begin
			if (tgt_s1.last_axis) begin
				mode_bad_q   <= 1'b0;
				check_fail_q <= 1'b0;
				write_fail_q <= 1'b0;
			end else begin
				mode_bad_q   <= mode_bad_n;
				check_fail_q <= check_fail_n;
				write_fail_q <= write_fail_n;
			end
		end
	end

	// Target store
	assign store_cmd.wr_en  = go_s1 && in_range;
	assign store_cmd.commit = go_s1 && tgt_s1.last_axis && commit;
	assign store_cmd.axis   = tgt_s1.axis_sel;
	assign store_cmd.target = tgt_s1.target;

	tgd_store #(
		.AXES (AXES)
	) u_store (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (store_cmd),
		.rd_axis       (tgt_s1.axis_sel),
		.rd_committed  (committed_rd),
		.has_committed (has_committed)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_vld_q <= 1'b0;
		end else if (go_s1 && tgt_s1.last_axis) begin
			res_vld_q <= 1'b1;
		end else if (!res_stall) begin
			res_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go_s1 && tgt_s1.last_axis) begin
			res_q.status  <= status_n;
			res_q.updated <= commit;
		end
	end

	assign res_valid = res_vld_q;
	assign res       = res_q;

`ifndef ASSERT_OFF
	// A round end always produces a result item
	a_round_end_result: assert property (@(posedge clk) disable iff (!arst_n)
		(go_s1 && tgt_s1.last_axis) |=> res_vld_q)
		else $error("round end did not produce a result");

	// Round flags are clear after a round end
	a_flags_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		(go_s1 && tgt_s1.last_axis) |=> (!mode_bad_q && !check_fail_q && !write_fail_q))
		else $error("round flags not cleared at round end");

	// A commit sets the committed flag
	a_commit_flag: assert property (@(posedge clk) disable iff (!arst_n)
		store_cmd.commit |=> has_committed)
		else $error("commit did not set the committed flag");

	// An updated round always reports ok
	a_updated_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res.updated) |-> (res.status == STATUS_OK))
		else $error("updated round reported invalid");
`endif

endmodule

FILE: design/tgd_check.sv
// Per-item target checks: soft limits, torque bound and step bound.
module tgd_check (
	input  tgd_pkg::tgd_in_t   item,
	input  logic [15:0]        torque_limit,
	input  logic [31:0]        max_step,
	input  logic               has_committed,
	input  logic signed [31:0] committed_target,
	output logic               ok
);
	import tgd_pkg::*;

	logic signed [32:0] tgt_w;
	logic signed [32:0] lim_w;
	logic signed [32:0] diff_w;
	logic [32:0]        diff_abs;
	logic               pos_fail;
	logic               torque_fail;
	logic               step_fail;

	// Position mode: limits must be known, equal limits mean unlimited
	always_comb begin
		pos_fail = 1'b0;
		if (item.mode == MODE_POSITION) begin
			if (!item.limits_known) begin
				pos_fail = 1'b1;
			end else if (item.limit_min != item.limit_max &&
			             (item.target < item.limit_min || item.target > item.limit_max)) begin
				pos_fail = 1'b1;
			end
		end
	end

	// Torque mode: magnitude bound, zero disables
	assign tgt_w = 33'(item.target);
	assign lim_w = signed'({17'b0, torque_limit});
	assign torque_fail = (item.mode == MODE_TORQUE) && (torque_limit != 16'd0) &&
	                     (tgt_w > lim_w || tgt_w < -lim_w);

	// Step from the last committed target outside torque mode, once anything was committed
	assign diff_w   = tgt_w - 33'(committed_target);
	assign diff_abs = diff_w[32] ? unsigned'(-diff_w) : unsigned'(diff_w);
	assign step_fail = (item.mode != MODE_TORQUE) && (max_step != 32'd0) && has_committed &&
	                   (diff_abs > {1'b0, max_step});

	assign ok = !(pos_fail || torque_fail || step_fail);

endmodule

FILE: design/tgd_store.sv
// Pending and committed target registers with the committed flag.
module tgd_store #(
	parameter int AXES = tgd_pkg::AXES_DEFAULT
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  tgd_pkg::tgd_store_cmd_t cmd,
	input  logic [tgd_pkg::AXIS_W-1:0] rd_axis,
	output logic signed [31:0]    rd_committed,
	output logic                  has_committed
);
	import tgd_pkg::*;

	// Only axes that the index field can reach need storage
	localparam int NSTORE = (AXES < (1 << AXIS_W)) ? AXES : (1 << AXIS_W);
	localparam int IW     = (NSTORE > 1) ? $clog2(NSTORE) : 1;

	logic signed [31:0] pending_q   [NSTORE];
	logic signed [31:0] committed_q [NSTORE];
	logic               has_committed_q;
	logic [IW-1:0]      wr_idx;
	logic [IW-1:0]      rd_idx;

	assign wr_idx = cmd.axis[IW-1:0];
	assign rd_idx = rd_axis[IW-1:0];

	// Pending write and full-round commit; an item written on the commit
	// cycle goes straight into the committed copy
	for (genvar i = 0; i < NSTORE; i++) begin : g_entry
		always_ff @(posedge clk) begin
			if (cmd.wr_en && wr_idx == IW'(i)) begin
				pending_q[i] <= cmd.target;
			end
			if (cmd.commit) begin
				if (cmd.wr_en && wr_idx == IW'(i)) begin
					committed_q[i] <= cmd.target;
				end else begin
					committed_q[i] <= pending_q[i];
				end
			end
		end
	end

	// Committed flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			has_committed_q <= 1'b0;
		end else if (cmd.commit) begin
			has_committed_q <= 1'b1;
		end
	end

	assign rd_committed  = committed_q[rd_idx];
	assign has_committed = has_committed_q;

endmodule

FILE: tb/sv/tb_top.sv
// Self-checking testbench for the multi-axis target guard: random rounds, stalls, predicted outcomes.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import tgd_pkg::*;

	localparam int AXES = AXES_DEFAULT;
	localparam int SETTLE = 16;
	localparam int ITEMS_PER_PHASE = 200;
	localparam int PHASES = 6;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int LONG_HOLD = 80;

	// Values outside the mode and source code sets
	localparam logic signed [7:0] MODE_UNSUPPORTED = 8'sd7;
	localparam logic [1:0] SRC_ERROR = 2'd2;
	localparam logic [1:0] SRC_ERROR_ALT = 2'd3;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic tgt_valid = 1'b0;
	logic tgt_stall;
	tgd_in_t tgt = '0;
	logic res_valid;
	logic res_stall = 1'b0;
	tgd_out_t res;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	multi_axis_target_guard #(.AXES(AXES)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.tgt_valid(tgt_valid),
		.tgt_stall(tgt_stall),
		.tgt(tgt),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res(res),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	// Pending items and predicted round outcomes
	tgd_in_t axis_items[$];
	tgd_out_t round_outcomes[$];
	int unsigned n_queued = 0;
	int unsigned n_accepted = 0;
	int unsigned n_results = 0;
	int unsigned fails = 0;
	bit no_idle = 1'b0;

	// Settings the generator aims its targets at
	logic [15:0] gen_torque = '0;
	logic [31:0] gen_step = '0;

	// Predictor state: configuration copy, staged and held targets, round flags
	logic [15:0] torque_bound = '0;
	logic [31:0] step_bound = '0;
	logic signed [31:0] staged_tgt [AXES];
	logic signed [31:0] held_tgt [AXES];
	bit commit_seen = 1'b0;
	bit rnd_bad_mode = 1'b0;
	bit rnd_bad_check = 1'b0;
	bit rnd_bad_write = 1'b0;

	// Per-axis checks: soft limits, torque bound, step from the held target
	function automatic bit target_passes(tgd_in_t it);
		longint t, lo, hi, lim, d;
		t = longint'($signed(it.target));
		lo = longint'($signed(it.limit_min));
		hi = longint'($signed(it.limit_max));
		if (it.mode == MODE_POSITION) begin
			if (!it.limits_known)
				return 1'b0;
			// equal limits mean no limit at all
			if (lo != hi && (t < lo || t > hi))
				return 1'b0;
		end
		if (it.mode == MODE_TORQUE && torque_bound != 0) begin
			lim = longint'(torque_bound);
			if (t > lim || t < -lim)
				return 1'b0;
		end
		if (it.mode != MODE_TORQUE && step_bound != 0 && commit_seen) begin
			d = t - longint'($signed(held_tgt[it.axis_sel]));
			if (d < 0)
				d = -d;
			if (d > longint'(step_bound))
				return 1'b0;
		end
		return 1'b1;
	endfunction

	// Fold one accepted item into the round; the last item yields the outcome
	function automatic void judge_axis_item(tgd_in_t it);
		tgd_out_t outcome;
		outcome.status = STATUS_OK;
		outcome.updated = 1'b0;
		if (it.mode != MODE_POSITION && it.mode != MODE_VELOCITY && it.mode != MODE_TORQUE)
			rnd_bad_mode = 1'b1;
		if (!it.write_ok)
			rnd_bad_write = 1'b1;
		if (int'(it.axis_sel) < AXES) begin
			staged_tgt[it.axis_sel] = it.target;
			if (!target_passes(it))
				rnd_bad_check = 1'b1;
		end
		if (!it.last_axis)
			return;
		// priority: bad mode, hold, source error, failed check or write
		if (rnd_bad_mode)
			outcome.status = STATUS_INVALID;
		else if (it.source_status == SRC_HOLD)
			outcome.status = STATUS_OK;
		else if (it.source_status != SRC_UPDATED)
			outcome.status = STATUS_INVALID;
		else if (rnd_bad_check || rnd_bad_write)
			outcome.status = STATUS_INVALID;
		else begin
			held_tgt = staged_tgt;
			commit_seen = 1'b1;
			outcome.updated = 1'b1;
		end
		rnd_bad_mode = 1'b0;
		rnd_bad_check = 1'b0;
		rnd_bad_write = 1'b0;
		round_outcomes.push_back(outcome);
	endfunction

	// Random idle bursts, with calm stretches in between
	function automatic bit take_idle(inout int unsigned gap, inout int unsigned calm);
		int unsigned r;
		if (gap != 0) begin
			gap--;
			return 1'b1;
		end
		if (calm != 0) begin
			calm--;
			return 1'b0;
		end
		r = $urandom_range(0, 15);
		if (r < 3) begin
			gap = $urandom_range(0, 3);
			return 1'b1;
		end
		if (r == 3)
			calm = $urandom_range(10, 40);
		return 1'b0;
	endfunction

	// Item driver: holds a stalled item, otherwise offers the next one or idles
	int unsigned tx_gap = 0;
	int unsigned tx_calm = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tgt_valid <= 1'b0;
			tgt <= '0;
		end else begin
			if (tgt_valid && !tgt_stall) begin
				judge_axis_item(tgt);
				n_accepted++;
			end
			if (!tgt_valid || !tgt_stall) begin
				if (!no_idle && take_idle(tx_gap, tx_calm))
					tgt_valid <= 1'b0;
				else if (axis_items.size() != 0) begin
					tgt <= axis_items.pop_front();
					tgt_valid <= 1'b1;
				end else
					tgt_valid <= 1'b0;
			end
		end
	end

	// Outcome monitor: compare with the oldest prediction, drive result stall
	tgd_out_t want;
	int unsigned rx_gap = 0;
	int unsigned rx_calm = 0;
	int unsigned hold_left = 0;
	bit hold_done = 1'b0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			res_stall <= 1'b0;
		else begin
			if (res_valid && !res_stall) begin
				n_results++;
				if (round_outcomes.size() == 0) begin
					$error("round outcome with no item pending: status %0d updated %0d",
						res.status, res.updated);
					fails++;
				end else begin
					want = round_outcomes.pop_front();
					if (res.status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, res.status);
						fails++;
					end
					if (res.updated !== want.updated) begin
						$error("updated: expected %0d, got %0d", want.updated, res.updated);
						fails++;
					end
				end
				// one long hold so the block backs up into its input
				if (n_results == 40 && !hold_done) begin
					hold_left = LONG_HOLD;
					hold_done = 1'b1;
				end
			end
			if (hold_left != 0) begin
				hold_left--;
				res_stall <= 1'b1;
			end else if (no_idle)
				res_stall <= 1'b0;
			else
				res_stall <= take_idle(rx_gap, rx_calm);
		end
	end

	// Configuration copy follows accepted register writes
	always @(posedge clk) begin
		if (arst_n && cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_TORQUE_LIMIT: torque_bound = cfg_data[15:0];
				REG_MAX_STEP: step_bound = cfg_data;
				default: ;
			endcase
		end
	end

	// Watchdog on cycles where nothing is accepted on any channel
	int unsigned quiet_cycles = 0;
	always @(posedge clk) begin
		if (!arst_n || (tgt_valid && !tgt_stall) || (res_valid && !res_stall)
				|| (cfg_valid && cfg_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles == WATCHDOG_LIMIT) begin
			$display("tb_top failed");
			$finish;
		end
	end

	task automatic add_item(logic [2:0] ax, logic signed [7:0] md, logic signed [31:0] tg,
			bit known, logic signed [31:0] lo, logic signed [31:0] hi, bit wok,
			logic [1:0] src, bit fin);
		tgd_in_t it;
		it.axis_sel = ax;
		it.mode = md;
		it.target = tg;
		it.limits_known = known;
		it.limit_min = lo;
		it.limit_max = hi;
		it.write_ok = wok;
		it.source_status = src;
		it.last_axis = fin;
		axis_items.push_back(it);
		n_queued++;
	endtask

	// One round: mostly well-formed items around zero, some full-width noise
	task automatic gen_round();
		int unsigned n, r, span;
		longint t;
		logic [2:0] ax;
		logic signed [7:0] md;
		logic signed [31:0] tg, lo, hi;
		bit known, wok, fin;
		logic [1:0] src;
		n = ($urandom_range(0, 7) == 0) ? AXES : $urandom_range(1, 5);
		for (int unsigned i = 0; i < n; i++) begin
			fin = (i == n - 1);
			if ($urandom_range(0, 9) == 0) begin
				add_item(3'($urandom), 8'($urandom), 32'($urandom), 1'($urandom),
					32'($urandom), 32'($urandom), 1'($urandom), 2'($urandom), fin);
				continue;
			end
			ax = 3'($urandom_range(0, AXES - 1));
			r = $urandom_range(0, 9);
			md = (r < 5) ? MODE_POSITION : (r < 9) ? MODE_VELOCITY : MODE_TORQUE;
			// spread targets just past the active bound so both sides get hit
			if (md == MODE_TORQUE)
				span = (gen_torque == 0) ? 100000 : gen_torque + gen_torque / 4 + 1;
			else if (gen_step == 0)
				span = 2000;
			else if (gen_step > 32'h3FFF_FFFF)
				span = 32'h7FFF_FFFF;
			else
				span = gen_step / 2 + gen_step / 8 + 1;
			t = longint'($urandom_range(0, 2 * span)) - longint'(span);
			tg = 32'(t);
			r = $urandom_range(0, 19);
			known = (r != 0);
			if (r == 1) begin
				lo = 32'($urandom);
				hi = lo;
			end else if (r == 2) begin
				lo = tg + 1;
				hi = tg + 1000;
			end else begin
				lo = 32'(t - longint'($urandom_range(0, 3000)));
				hi = 32'(t + longint'($urandom_range(0, 3000)));
			end
			wok = ($urandom_range(0, 29) != 0);
			if (!fin)
				src = 2'($urandom);
			else begin
				r = $urandom_range(0, 19);
				src = (r < 16) ? SRC_UPDATED : (r < 18) ? SRC_HOLD :
					(r == 18) ? SRC_ERROR : SRC_ERROR_ALT;
			end
			add_item(ax, md, tg, known, lo, hi, wok, src, fin);
		end
	endtask

	// Wait until every item is in and every outcome is out, then let the block settle
	task automatic drain();
		while (n_accepted != n_queued || round_outcomes.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	// Stimulus: directed rounds, then random phases under several settings
	initial begin
		logic [15:0] torque_val;
		logic [31:0] step_val;
		int unsigned phase_base;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// first round writes every axis, extremes on axes 0 and 1, and commits
		add_item(3'd0, MODE_VELOCITY, 32'h8000_0000, 1'b0, '0, '0, 1'b1, SRC_UPDATED, 1'b0);
		add_item(3'd1, MODE_VELOCITY, 32'h7FFF_FFFF, 1'b0, '0, '0, 1'b1, SRC_UPDATED, 1'b0);
		for (int a = 2; a < 7; a++)
			add_item(3'(a), MODE_POSITION, 32'(a * 100), 1'b1, 32'h8000_0000, 32'h7FFF_FFFF,
				1'b1, SRC_UPDATED, 1'b0);
		add_item(3'd7, MODE_TORQUE, -32'sd5, 1'b1, '0, '0, 1'b1, SRC_UPDATED, 1'b1);
		// position with unread limits
		add_item(3'd2, MODE_POSITION, '0, 1'b0, -32'sd10, 32'sd10, 1'b1, SRC_UPDATED, 1'b1);
		// equal limits leave the target free
		add_item(3'd2, MODE_POSITION, 32'h8000_0000, 1'b1, 32'sd5, 32'sd5, 1'b1,
			SRC_UPDATED, 1'b1);
		// one past the upper limit, then exactly on the lower one
		add_item(3'd3, MODE_POSITION, 32'sd11, 1'b1, -32'sd10, 32'sd10, 1'b1, SRC_UPDATED, 1'b1);
		add_item(3'd3, MODE_POSITION, -32'sd10, 1'b1, -32'sd10, 32'sd10, 1'b1,
			SRC_UPDATED, 1'b1);
		// torque bound of zero means no bound
		add_item(3'd4, MODE_TORQUE, 32'h7FFF_FFFF, 1'b0, '0, '0, 1'b1, SRC_UPDATED, 1'b1);
		// bad mode wins over a hold
		add_item(3'd5, 8'sh80, '0, 1'b1, '0, '0, 1'b1, SRC_HOLD, 1'b1);
		// bad mode on an earlier item spoils the round
		add_item(3'd5, MODE_UNSUPPORTED, '0, 1'b1, '0, '0, 1'b1, SRC_UPDATED, 1'b0);
		add_item(3'd6, MODE_VELOCITY, '0, 1'b1, '0, '0, 1'b1, SRC_UPDATED, 1'b1);
		// hold hides both a failed check and a failed write
		add_item(3'd3, MODE_POSITION, 32'sd100, 1'b0, '0, '0, 1'b0, SRC_HOLD, 1'b1);
		// both source error codes
		add_item(3'd1, MODE_VELOCITY, '0, 1'b1, '0, '0, 1'b1, SRC_ERROR, 1'b1);
		add_item(3'd1, MODE_VELOCITY, '0, 1'b1, '0, '0, 1'b1, SRC_ERROR_ALT, 1'b1);
		// failed device write
		add_item(3'd1, MODE_VELOCITY, '0, 1'b1, '0, '0, 1'b0, SRC_UPDATED, 1'b1);
		// source status counts only on the last item
		add_item(3'd0, MODE_VELOCITY, '0, 1'b1, '0, '0, 1'b1, SRC_ERROR, 1'b0);
		add_item(3'd1, MODE_VELOCITY, '0, 1'b1, '0, '0, 1'b1, SRC_UPDATED, 1'b1);
		// top mode value
		add_item(3'd0, 8'sh7F, -32'sd1, 1'b1, -32'sd1, -32'sd1, 1'b1, SRC_UPDATED, 1'b1);

		for (int p = 0; p < PHASES; p++) begin
			if (p != 0) begin
				drain();
				case (p)
					1: begin torque_val = 16'd1000; step_val = 32'd5000; end
					2: begin torque_val = 16'hFFFF; step_val = 32'hFFFF_FFFF; end
					3: begin torque_val = 16'd1; step_val = 32'd1; end
					4: begin torque_val = 16'd0; step_val = 32'd0; end
					default: begin
						torque_val = 16'($urandom_range(1, 65535));
						step_val = $urandom_range(1, 100000);
					end
				endcase
				write_reg(REG_TORQUE_LIMIT, {16'd0, torque_val});
				write_reg(REG_MAX_STEP, step_val);
				gen_torque = torque_val;
				gen_step = step_val;
			end
			if (p == 2) begin
				// widest possible step: full-scale swing on one axis still passes
				add_item(3'd0, MODE_VELOCITY, 32'h8000_0000, 1'b1, '0, '0, 1'b1,
					SRC_UPDATED, 1'b1);
				add_item(3'd0, MODE_VELOCITY, 32'h7FFF_FFFF, 1'b1, '0, '0, 1'b1,
					SRC_UPDATED, 1'b1);
			end
			// last phase runs with no idling on either side
			if (p == PHASES - 1)
				no_idle = 1'b1;
			phase_base = n_queued;
			while (n_queued - phase_base < ITEMS_PER_PHASE)
				gen_round();
		end
		drain();

		if (fails == 0)
			$display("tb_top passed");
		else
			$display("tb_top failed");
		$finish;
	end

endmodule

FILE: multi_axis_target_guard.f
design/tgd_pkg.sv
design/tgd_check.sv
design/tgd_store.sv
design/multi_axis_target_guard.sv
tb/sv/tb_top.sv
